### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/fhp_pkg.sv
// ----------------------------------------------------------------------------
// fhp_pkg
// Types and constants shared by the Horner polynomial evaluator.
// ----------------------------------------------------------------------------
package fhp_pkg;

	// Width of the signed degree register.
	localparam int DEG_W = 4;
	localparam int DEG_RESET = 3;

	// Fixed-point scale of the evaluation point: 10 fraction bits.
	localparam int FRAC_BITS = 10;

	// Reset values of the coefficients, lowest order first.
	localparam int MAX_COEFS = 7;
	localparam int COEF_RESET [MAX_COEFS] = '{100, 2500, -100, 1, 0, 0, 0};

	// Register index of the degree; coefficient k sits at index k + 1.
	localparam int REG_DEGREE = 0;
	localparam int REG_COEF_BASE = 1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;   // capture x and load the accumulator
		logic clear;  // with take: load zero instead of a coefficient
		logic mul;    // register acc * x
		logic add;    // scale the product and add a coefficient
	} fhp_cmd_t;

endpackage

### rtl/core/fhp_cfg_regs.sv
// ----------------------------------------------------------------------------
// fhp_cfg_regs
// Degree and coefficient registers with a write port and one read port.
// ----------------------------------------------------------------------------
module fhp_cfg_regs #(
	parameter int MAX_DEGREE = 6,
	parameter int DATA_WIDTH = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [$clog2(MAX_DEGREE+2)-1:0]       cfg_index,
	input  logic [DATA_WIDTH-1:0]                 cfg_wdata,
	input  logic [$clog2(MAX_DEGREE+1)-1:0]       rd_idx,
	output logic signed [DATA_WIDTH-1:0]          rd_coef,
	output logic [fhp_pkg::DEG_W-1:0]             degree
);
	import fhp_pkg::*;

	localparam int NUM_COEF = MAX_DEGREE + 1;
	localparam int CFG_IDX_W = $clog2(MAX_DEGREE + 2);

	logic [DEG_W-1:0]             degree_q;
	logic signed [DATA_WIDTH-1:0] coef_q [NUM_COEF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEG_W'(DEG_RESET);
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= DATA_WIDTH'(COEF_RESET[i]);
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_IDX_W'(REG_DEGREE)) begin
				degree_q <= cfg_wdata[DEG_W-1:0];
			end
			for (int i = 0; i < NUM_COEF; i++) begin
				if (cfg_index == CFG_IDX_W'(REG_COEF_BASE + i)) begin
					coef_q[i] <= cfg_wdata;
				end
			end
		end
	end

	assign rd_coef = coef_q[rd_idx];
	assign degree  = degree_q;

endmodule

### rtl/core/fhp_dp.sv
// ----------------------------------------------------------------------------
// fhp_dp
// Horner datapath: accumulator, shared multiplier and scaled add.
// ----------------------------------------------------------------------------
module fhp_dp #(
	parameter int DATA_WIDTH = 20
) (
	input  logic                         clk,
	input  fhp_pkg::fhp_cmd_t            cmd,
	input  logic signed [DATA_WIDTH-1:0] x_value,
	input  logic signed [DATA_WIDTH-1:0] coef,
	output logic signed [DATA_WIDTH-1:0] acc
);
	import fhp_pkg::*;

	localparam int PROD_W = 2 * DATA_WIDTH;

	logic signed [DATA_WIDTH-1:0] x_q;
	logic signed [DATA_WIDTH-1:0] acc_q;
	logic signed [PROD_W-1:0]     prod_s1;
	logic signed [PROD_W-1:0]     biased;
	logic signed [PROD_W-1:0]     quot;

	// Division by 2^FRAC_BITS rounding toward zero: bias negative products
	// by one less than the divisor before the arithmetic shift.
	always_comb begin
		biased = prod_s1 + (prod_s1[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
		quot   = biased >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q   <= x_value;
			acc_q <= cmd.clear ? '0 : coef;
		end
		if (cmd.mul) begin
			prod_s1 <= acc_q * x_q;
		end
		if (cmd.add) begin
			acc_q <= quot[DATA_WIDTH-1:0] + coef;
		end
	end

	assign acc = acc_q;

endmodule

### rtl/core/fhp_ctrl.sv
// ----------------------------------------------------------------------------
// fhp_ctrl
// Controller that sequences a multiply and an add per non-leading coefficient.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fhp_ctrl #(
	parameter int MAX_DEGREE = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [fhp_pkg::DEG_W-1:0]           degree,
	output logic                                busy,
	output logic                                done,
	output logic [$clog2(MAX_DEGREE+1)-1:0]     coef_idx,
	output fhp_pkg::fhp_cmd_t                   cmd
);
	import fhp_pkg::*;

	localparam int IDX_W = $clog2(MAX_DEGREE + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] step_q;
	logic             done_q;
	logic             deg_neg;
	logic [IDX_W-1:0] deg_sat;

	// Degrees above the supported maximum evaluate as the maximum.
	always_comb begin
		deg_neg = degree[DEG_W-1];
		if (int'(degree[DEG_W-2:0]) > MAX_DEGREE) begin
			deg_sat = IDX_W'(MAX_DEGREE);
		end else begin
			deg_sat = IDX_W'(degree[DEG_W-2:0]);
		end
	end

	always_comb begin
		cmd      = '0;
		coef_idx = step_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take  = start;
				cmd.clear = deg_neg;
				coef_idx  = deg_sat;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (deg_neg || deg_sat == '0) begin
							done_q <= 1'b1;
						end else begin
							step_q  <= deg_sat - IDX_W'(1);
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (step_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						step_q  <= step_q - IDX_W'(1);
						state_q <= ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	`ASSERT_CLK(a_done_idle, clk, arst_n, done |-> !busy, "result strobe while busy")
	`ASSERT_CLK(a_busy_start, clk, arst_n, $rose(busy) |-> $past(start), "busy rose without a start")
	`ASSERT_CLK(a_mul_add, clk, arst_n, cmd.mul |=> cmd.add, "multiply not followed by add")
	`ASSERT_CLK(a_cmd_onehot, clk, arst_n, $onehot0({cmd.take, cmd.mul, cmd.add}), "more than one command")

endmodule

### rtl/core/fixed_point_horner_poly.sv
// ----------------------------------------------------------------------------
// fixed_point_horner_poly
// Fixed-point polynomial evaluator using Horner's rule.
//
//   Channel   Signals                              Direction
//   -------   ----------------------------------   ---------
//   input     start, busy, x_value                 in / out
//   result    done, poly_value                     out
//   config    cfg_wr_en, cfg_index, cfg_wdata      in
//
// A transaction is taken when start is high and busy is low. With an
// effective degree d >= 1 the result strobe done rises after d multiply
// states and d add states, and a new transaction can be taken while done is
// high; a degree of zero or below raises done without going busy. The single
// shared multiplier is used once per coefficient below the leading one, with
// the scaled add in the following cycle. Reset restores the example
// polynomial. The result is shown for one cycle and is not held back.
// ----------------------------------------------------------------------------
module fixed_point_horner_poly #(
	parameter int MAX_DEGREE = 6,
	parameter int DATA_WIDTH = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [DATA_WIDTH-1:0]      x_value,
	output logic                              done,
	output logic signed [DATA_WIDTH-1:0]      poly_value,
	input  logic                              cfg_wr_en,
	input  logic [$clog2(MAX_DEGREE+2)-1:0]   cfg_index,
	input  logic [DATA_WIDTH-1:0]             cfg_wdata
);
	import fhp_pkg::*;

	localparam int IDX_W = $clog2(MAX_DEGREE + 1);

	fhp_cmd_t                     cmd;
	logic [IDX_W-1:0]             coef_idx;
	logic signed [DATA_WIDTH-1:0] coef;
	logic [DEG_W-1:0]             degree;

	fhp_cfg_regs #(
		.MAX_DEGREE (MAX_DEGREE),
		.DATA_WIDTH (DATA_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rd_idx    (coef_idx),
		.rd_coef   (coef),
		.degree    (degree)
	);

	fhp_ctrl #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.degree   (degree),
		.busy     (busy),
		.done     (done),
		.coef_idx (coef_idx),
		.cmd      (cmd)
	);

	fhp_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.x_value (x_value),
		.coef    (coef),
		.acc     (poly_value)
	);

endmodule
